>>> sv/sat_pkg.sv
// Package with the shared types and constants of the sorted array table.
package sat_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned STAT_W  = 2;

	localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(16);

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_INSERT_LAST,
		ST_REMOVE,
		ST_READ
	} state_t;

endpackage

>>> sv/sorted_array_table.sv
// Sorted array table: ascending table of 32-bit values with insert, remove and read.
//
//  channel   signals                        direction  transaction
//  request   start, busy, req               in         start & !busy
//  result    done, result                   out        done (one cycle, no hold-off)
//  config    cfg_valid, cfg_ready, cfg_data in         cfg_valid & cfg_ready
//
// Insert walks the table from the top entry down, one entry per cycle, with at most
// one read and one write of the entry memory each cycle. Remove walks up from
// index + 1 to the top. Read goes via ST_READ; refused, no-op and empty-table
// requests and top-entry removal finish in ST_IDLE. The result strobe is registered
// and rises in the cycle after the last step. Reset clears the count and sets
// capacity to 16. The receiver cannot stall; busy holds requests off during a walk.
module sorted_array_table #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  sat_pkg::req_t               req,
	output logic                        done,
	output sat_pkg::rsp_t               result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sat_pkg::COUNT_W-1:0] cfg_data
);

	localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LIMIT_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam logic [sat_pkg::COUNT_W-1:0] DEPTH_LIMIT = sat_pkg::COUNT_W'(LIMIT_MAX);

	logic [sat_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [sat_pkg::VALUE_W-1:0] rd_q;

	sat_pkg::state_t state_q, state_d;

	logic [sat_pkg::COUNT_W-1:0] count_q, count_d;
	logic [sat_pkg::COUNT_W-1:0] cap_q;
	logic [sat_pkg::COUNT_W-1:0] ptr_q, ptr_d;
	logic [sat_pkg::VALUE_W-1:0] value_q, value_d;

	logic                        we, re;
	logic [AW-1:0]               wa, ra;
	logic [sat_pkg::VALUE_W-1:0] wd;

	logic          done_d;
	sat_pkg::rsp_t res_d;
	logic          accept, full, bad_index;
	logic [sat_pkg::COUNT_W-1:0] index_ext;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != sat_pkg::ST_IDLE);
	assign accept    = start & ~busy;
	assign index_ext = sat_pkg::COUNT_W'(req.index);
	assign full      = (count_q >= cap_q) || (count_q >= DEPTH_LIMIT);
	assign bad_index = (index_ext >= count_q);

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sat_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= sat_pkg::CAP_RESET;
			done    <= 1'b0;
		end else begin
			count_q <= count_d;
			done    <= done_d;
			if (cfg_valid && cfg_ready)
				cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q   <= ptr_d;
		value_q <= value_d;
		if (done_d)
			result <= res_d;
	end

	always_comb begin
		state_d          = state_q;
		count_d          = count_q;
		ptr_d            = ptr_q;
		value_d          = value_q;
		we               = 1'b0;
		wa               = '0;
		wd               = value_q;
		re               = 1'b0;
		ra               = '0;
		done_d           = 1'b0;
		res_d.read_value = '0;
		res_d.status     = sat_pkg::STAT_OK;
		res_d.count      = count_q;

		unique case (state_q)
			sat_pkg::ST_IDLE: begin
				if (accept) begin
					value_d = req.value;
					case (req.func)
						sat_pkg::FUNC_INSERT: begin
							if (full) begin
								done_d       = 1'b1;
								res_d.status = sat_pkg::STAT_FULL;
							end else if (count_q == '0) begin
								we          = 1'b1;
								wa          = '0;
								wd          = req.value;
								count_d     = count_q + 1'b1;
								done_d      = 1'b1;
								res_d.count = count_q + 1'b1;
							end else begin
								ptr_d   = count_q - 1'b1;
								re      = 1'b1;
								ra      = AW'(count_q - 1'b1);
								state_d = sat_pkg::ST_INSERT;
							end
						end
						sat_pkg::FUNC_REMOVE: begin
							if (bad_index) begin
								done_d       = 1'b1;
								res_d.status = sat_pkg::STAT_BAD_INDEX;
							end else if (index_ext + 1'b1 == count_q) begin
								count_d     = count_q - 1'b1;
								done_d      = 1'b1;
								res_d.count = count_q - 1'b1;
							end else begin
								ptr_d   = index_ext + 1'b1;
								re      = 1'b1;
								ra      = AW'(index_ext + 1'b1);
								state_d = sat_pkg::ST_REMOVE;
							end
						end
						sat_pkg::FUNC_READ: begin
							if (bad_index) begin
								done_d       = 1'b1;
								res_d.status = sat_pkg::STAT_BAD_INDEX;
							end else begin
								re      = 1'b1;
								ra      = AW'(index_ext);
								state_d = sat_pkg::ST_READ;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			sat_pkg::ST_INSERT: begin
				we = 1'b1;
				wa = AW'(ptr_q + 1'b1);
				if (rd_q >= value_q) begin
					wd = rd_q;
					if (ptr_q == '0) begin
						state_d = sat_pkg::ST_INSERT_LAST;
					end else begin
						ptr_d = ptr_q - 1'b1;
						re    = 1'b1;
						ra    = AW'(ptr_q - 1'b1);
					end
				end else begin
					wd          = value_q;
					count_d     = count_q + 1'b1;
					done_d      = 1'b1;
					res_d.count = count_q + 1'b1;
					state_d     = sat_pkg::ST_IDLE;
				end
			end
			sat_pkg::ST_INSERT_LAST: begin
				we          = 1'b1;
				wa          = '0;
				wd          = value_q;
				count_d     = count_q + 1'b1;
				done_d      = 1'b1;
				res_d.count = count_q + 1'b1;
				state_d     = sat_pkg::ST_IDLE;
			end
			sat_pkg::ST_REMOVE: begin
				we = 1'b1;
				wa = AW'(ptr_q - 1'b1);
				wd = rd_q;
				if (ptr_q + 1'b1 == count_q) begin
					count_d     = count_q - 1'b1;
					done_d      = 1'b1;
					res_d.count = count_q - 1'b1;
					state_d     = sat_pkg::ST_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
					re    = 1'b1;
					ra    = AW'(ptr_q + 1'b1);
				end
			end
			sat_pkg::ST_READ: begin
				done_d           = 1'b1;
				res_d.read_value = rd_q;
				state_d          = sat_pkg::ST_IDLE;
			end
			default: begin
				state_d = sat_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
